// ----- sv/kma_pkg.sv -----
// Shared types and constants for the k-means assign and update block.
package kma_pkg;

    localparam int DIST_BITS = 36;
    localparam int SUM_BITS  = 36;
    localparam int OUT_COUNT_BITS = 20;
    localparam int OUT_CLUSTER_BITS = 9;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_POINT  = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // Register index as decoded from paddr[2].
    localparam logic REG_CLUSTERS = 1'b0;
    localparam logic REG_DIMS     = 1'b1;

    localparam logic [9:0] CLUSTERS_RESET = 10'd512;
    localparam logic [3:0] DIMS_RESET     = 4'd14;

    // Tags that travel with one coordinate through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic final_item;
    } dist_ctl_t;

endpackage

// ----- sv/kmeans_assign_and_update_core.sv -----
// Top level of the k-means assign and update block.
//
// Commands are taken when start is high and busy is low; each result appears for one
// cycle with result_valid and cannot be stalled. Loading a centroid coordinate and
// buffering a non-final point coordinate leave busy low. The final point coordinate
// starts a search through the shared subtract-square-accumulate unit at one centroid
// coordinate per cycle, then adds the point to the winning cluster's sums over the
// sums memory port unless its count is full. An update forms each mean with the
// bit-serial divider. After reset the block clears the sums and counts memories
// with busy high.
module kmeans_assign_and_update_core #(
    parameter int MAX_CLUSTERS = 512,
    parameter int MAX_DIMS     = 14,
    parameter int COORD_BITS   = 16,
    parameter int COUNT_BITS   = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [8:0]  cluster_index,
    input  logic [3:0]  dim_index,
    input  logic signed [15:0] coord_value,
    output logic        result_valid,
    output logic        result_kind,
    output logic [8:0]  best_cluster,
    output logic [35:0] best_distance,
    output logic [19:0] member_count,
    output logic        cluster_empty
);

    localparam int DEPTH = MAX_CLUSTERS * MAX_DIMS;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(MAX_CLUSTERS);
    localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SB = kma_pkg::SUM_BITS;
    localparam logic signed [32:0] CMAX = 33'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic signed [32:0] CMIN = -CMAX - 33'sd1;
    localparam logic signed [SB:0] SUM_MAX = (SB+1)'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [SB:0] SUM_MIN = -SUM_MAX - $signed((SB+1)'(1));

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ASSIGN, ST_DRAIN, ST_ACC_CNT, ST_ACC_CHK,
        ST_SUM_RD, ST_SUM_WR, ST_UPD_CNT, ST_UPD_CHK, ST_UPD_RD, ST_UPD_DATA,
        ST_UPD_DIV
    } state_t;

    state_t state_reg;

    logic [9:0] clusters_reg;
    logic [3:0] dims_reg;
    logic [CW-1:0] nc_m1;
    logic [DW-1:0] nd_m1;

    logic signed [COORD_BITS-1:0] pb_reg [MAX_DIMS];
    logic [DW-1:0] pb_idx;
    logic signed [COORD_BITS-1:0] pb_rd;

    logic [AW-1:0] clr_reg;
    logic [CW-1:0] iss_c_reg;
    logic [DW-1:0] iss_d_reg;
    logic [AW-1:0] iss_base_reg;
    kma_pkg::dist_ctl_t s1_ctl_reg;
    logic [CW-1:0] s1_c_reg;
    logic [DW-1:0] s1_d_reg;
    logic [CW-1:0] best_c_reg;
    logic [kma_pkg::DIST_BITS-1:0] best_d_reg;
    logic [CW-1:0] uc_reg;
    logic [DW-1:0] d_reg;
    logic [AW-1:0] base_reg;
    logic [AW-1:0] sum_addr_reg;
    logic [COUNT_BITS-1:0] cnt_val_reg;
    logic sign_reg;

    logic result_valid_reg, result_kind_reg, cluster_empty_reg;
    logic [8:0]  best_cluster_reg;
    logic [35:0] best_distance_reg;
    logic [19:0] member_count_reg;

    logic accept, cfg_write;
    logic signed [32:0] v_ext;
    logic signed [COORD_BITS-1:0] val_c;
    logic [AW-1:0] load_addr;
    logic load_we;

    logic cen_we;
    logic [AW-1:0] cen_waddr, cen_raddr;
    logic signed [COORD_BITS-1:0] cen_wdata, cen_rdata;
    logic sum_we;
    logic [AW-1:0] sum_waddr, sum_raddr;
    logic [SB-1:0] sum_wdata, sum_rdata;
    logic cnt_we;
    logic [CW-1:0] cnt_waddr, cnt_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;

    logic signed [SB:0] sum_add;
    logic [SB-1:0] sat_sum;
    logic [SB-1:0] sum_mag;
    logic div_start, div_done;
    logic [SB-1:0] quot;
    logic signed [COORD_BITS-1:0] mean_val;
    logic [31:0] cnt_ext;

    logic dist_valid, dist_final;
    logic [CW-1:0] dist_c;
    logic [kma_pkg::DIST_BITS-1:0] dist_val;

    assign pready    = 1'b1;
    assign busy      = state_reg != ST_IDLE;
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            kma_pkg::REG_CLUSTERS: prdata = {22'd0, clusters_reg};
            kma_pkg::REG_DIMS:     prdata = {28'd0, dims_reg};
            default:               prdata = '0;
        endcase
    end

    always_comb
    begin
        if (clusters_reg == 10'd0)
            nc_m1 = '0;
        else if (int'(clusters_reg) > MAX_CLUSTERS)
            nc_m1 = CW'(MAX_CLUSTERS - 1);
        else
            nc_m1 = CW'(clusters_reg - 10'd1);
        if (dims_reg == 4'd0)
            nd_m1 = '0;
        else if (int'(dims_reg) > MAX_DIMS)
            nd_m1 = DW'(MAX_DIMS - 1);
        else
            nd_m1 = DW'(dims_reg - 4'd1);
    end

    // Input coordinates are clamped to the stored coordinate range.
    assign v_ext = 33'(coord_value);
    always_comb
    begin
        if (v_ext > CMAX)
            val_c = CMAX[COORD_BITS-1:0];
        else if (v_ext < CMIN)
            val_c = CMIN[COORD_BITS-1:0];
        else
            val_c = v_ext[COORD_BITS-1:0];
    end

    assign load_addr = AW'(int'(cluster_index) * MAX_DIMS + int'(dim_index));
    assign load_we   = accept && command == kma_pkg::CMD_LOAD
                       && int'(cluster_index) < MAX_CLUSTERS && int'(dim_index) < MAX_DIMS;

    assign pb_idx = (state_reg == ST_ASSIGN || state_reg == ST_DRAIN) ? s1_d_reg : d_reg;
    assign pb_rd  = pb_reg[pb_idx];

    assign sum_add = $signed(sum_rdata) + pb_rd;
    always_comb
    begin
        if (sum_add > SUM_MAX)
            sat_sum = SUM_MAX[SB-1:0];
        else if (sum_add < SUM_MIN)
            sat_sum = SUM_MIN[SB-1:0];
        else
            sat_sum = sum_add[SB-1:0];
    end

    assign sum_mag = sum_rdata[SB-1] ? SB'(-$signed(sum_rdata)) : sum_rdata;

    always_comb
    begin
        if (!sign_reg)
            mean_val = (quot > SB'(CMAX)) ? CMAX[COORD_BITS-1:0] : quot[COORD_BITS-1:0];
        else if (quot > SB'(CMAX) + SB'(1))
            mean_val = CMIN[COORD_BITS-1:0];
        else
            mean_val = COORD_BITS'(-quot);
    end

    assign cnt_ext = 32'(cnt_val_reg);

    always_comb
    begin
        cen_we    = load_we || (state_reg == ST_UPD_DIV && div_done);
        cen_waddr = load_we ? load_addr : sum_addr_reg;
        cen_wdata = load_we ? val_c : mean_val;
        cen_raddr = iss_base_reg + AW'(iss_d_reg);

        sum_we    = state_reg == ST_CLEAR || state_reg == ST_SUM_WR
                    || state_reg == ST_UPD_DATA;
        sum_waddr = (state_reg == ST_CLEAR) ? clr_reg : sum_addr_reg;
        sum_wdata = (state_reg == ST_SUM_WR) ? sat_sum : '0;
        sum_raddr = base_reg + AW'(d_reg);

        cnt_we    = (state_reg == ST_CLEAR && int'(clr_reg) < MAX_CLUSTERS)
                    || (state_reg == ST_ACC_CHK && cnt_rdata != '1)
                    || state_reg == ST_UPD_CHK;
        cnt_waddr = (state_reg == ST_CLEAR) ? clr_reg[CW-1:0]
                  : (state_reg == ST_ACC_CHK) ? best_c_reg : uc_reg;
        cnt_wdata = (state_reg == ST_ACC_CHK) ? cnt_rdata + 1'b1 : '0;
        cnt_raddr = (state_reg == ST_ACC_CNT) ? best_c_reg : uc_reg;

        div_start = state_reg == ST_UPD_DATA && cnt_val_reg != '0 && d_reg <= nd_m1;
    end

    kma_ram #(.WIDTH(COORD_BITS), .DEPTH(DEPTH)) u_centroids (
        .clk(clk), .we(cen_we), .waddr(cen_waddr), .wdata(cen_wdata),
        .raddr(cen_raddr), .rdata(cen_rdata)
    );

    kma_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_sums (
        .clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
        .raddr(sum_raddr), .rdata(sum_rdata)
    );

    kma_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_CLUSTERS)) u_counts (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    kma_dist #(.COORD_BITS(COORD_BITS), .CW(CW)) u_dist (
        .clk(clk), .rst_n(rst_n), .ctl(s1_ctl_reg), .cluster_in(s1_c_reg),
        .pt(pb_rd), .cen(cen_rdata), .out_valid(dist_valid), .out_final(dist_final),
        .out_cluster(dist_c), .out_dist(dist_val)
    );

    kma_div #(.NUM_BITS(SB), .DEN_BITS(COUNT_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(sum_mag),
        .den(cnt_val_reg), .done(div_done), .quot(quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clusters_reg     <= kma_pkg::CLUSTERS_RESET;
            dims_reg         <= kma_pkg::DIMS_RESET;
            clr_reg          <= '0;
            s1_ctl_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            s1_ctl_reg       <= '0;

            if (cfg_write)
            begin
                unique case (paddr[2])
                    kma_pkg::REG_CLUSTERS: clusters_reg <= pwdata[9:0];
                    kma_pkg::REG_DIMS:     dims_reg     <= pwdata[3:0];
                    default:               ;
                endcase
            end

            if (dist_valid && (dist_c == '0 || dist_val < best_d_reg))
            begin
                best_c_reg <= dist_c;
                best_d_reg <= dist_val;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (accept && command == kma_pkg::CMD_POINT
                        && 32'(dim_index) <= 32'(nd_m1))
                    begin
                        pb_reg[DW'(dim_index)] <= val_c;
                        if (32'(dim_index) == 32'(nd_m1))
                        begin
                            iss_c_reg    <= '0;
                            iss_d_reg    <= '0;
                            iss_base_reg <= '0;
                            state_reg    <= ST_ASSIGN;
                        end
                    end
                    else if (accept && command == kma_pkg::CMD_UPDATE
                             && int'(cluster_index) < MAX_CLUSTERS)
                    begin
                        uc_reg    <= CW'(cluster_index);
                        state_reg <= ST_UPD_CNT;
                    end
                end
                ST_ASSIGN:
                begin
                    s1_ctl_reg.valid      <= 1'b1;
                    s1_ctl_reg.first      <= iss_d_reg == '0;
                    s1_ctl_reg.last       <= iss_d_reg == nd_m1;
                    s1_ctl_reg.final_item <= iss_d_reg == nd_m1 && iss_c_reg == nc_m1;
                    s1_c_reg <= iss_c_reg;
                    s1_d_reg <= iss_d_reg;
                    if (iss_d_reg == nd_m1)
                    begin
                        iss_d_reg    <= '0;
                        iss_c_reg    <= iss_c_reg + 1'b1;
                        iss_base_reg <= iss_base_reg + AW'(MAX_DIMS);
                        if (iss_c_reg == nc_m1)
                            state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        iss_d_reg <= iss_d_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (dist_final)
                        state_reg <= ST_ACC_CNT;
                end
                ST_ACC_CNT:
                begin
                    base_reg  <= AW'(int'(best_c_reg) * MAX_DIMS);
                    d_reg     <= '0;
                    state_reg <= ST_ACC_CHK;
                end
                ST_ACC_CHK:
                begin
                    // A full counter leaves the cluster untouched.
                    if (cnt_rdata != '1)
                    begin
                        state_reg <= ST_SUM_RD;
                    end
                    else
                    begin
                        result_valid_reg  <= 1'b1;
                        result_kind_reg   <= kma_pkg::KIND_ASSIGN;
                        best_cluster_reg  <= 9'(best_c_reg);
                        best_distance_reg <= best_d_reg;
                        member_count_reg  <= '0;
                        cluster_empty_reg <= 1'b0;
                        state_reg         <= ST_IDLE;
                    end
                end
                ST_SUM_RD:
                begin
                    sum_addr_reg <= sum_raddr;
                    state_reg    <= ST_SUM_WR;
                end
                ST_SUM_WR:
                begin
                    if (d_reg == nd_m1)
                    begin
                        result_valid_reg  <= 1'b1;
                        result_kind_reg   <= kma_pkg::KIND_ASSIGN;
                        best_cluster_reg  <= 9'(best_c_reg);
                        best_distance_reg <= best_d_reg;
                        member_count_reg  <= '0;
                        cluster_empty_reg <= 1'b0;
                        state_reg         <= ST_IDLE;
                    end
                    else
                    begin
                        d_reg     <= d_reg + 1'b1;
                        state_reg <= ST_SUM_RD;
                    end
                end
                ST_UPD_CNT:
                begin
                    base_reg  <= AW'(int'(uc_reg) * MAX_DIMS);
                    d_reg     <= '0;
                    state_reg <= ST_UPD_CHK;
                end
                ST_UPD_CHK:
                begin
                    cnt_val_reg <= cnt_rdata;
                    state_reg   <= ST_UPD_RD;
                end
                ST_UPD_RD:
                begin
                    sum_addr_reg <= sum_raddr;
                    state_reg    <= ST_UPD_DATA;
                end
                ST_UPD_DATA, ST_UPD_DIV:
                begin
                    if (state_reg == ST_UPD_DATA)
                        sign_reg <= sum_rdata[SB-1];
                    if (div_start)
                    begin
                        state_reg <= ST_UPD_DIV;
                    end
                    else if (state_reg == ST_UPD_DIV && !div_done)
                    begin
                        state_reg <= ST_UPD_DIV;
                    end
                    else if (d_reg == DW'(MAX_DIMS - 1))
                    begin
                        result_valid_reg  <= 1'b1;
                        result_kind_reg   <= kma_pkg::KIND_UPDATE;
                        best_cluster_reg  <= 9'(uc_reg);
                        best_distance_reg <= '0;
                        member_count_reg  <= (cnt_ext > 32'hFFFFF) ? 20'hFFFFF : cnt_ext[19:0];
                        cluster_empty_reg <= cnt_val_reg == '0;
                        state_reg         <= ST_IDLE;
                    end
                    else
                    begin
                        d_reg     <= d_reg + 1'b1;
                        state_reg <= ST_UPD_RD;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result_valid  = result_valid_reg;
    assign result_kind   = result_kind_reg;
    assign best_cluster  = best_cluster_reg;
    assign best_distance = best_distance_reg;
    assign member_count  = member_count_reg;
    assign cluster_empty = cluster_empty_reg;

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("two results in consecutive cycles");

    a_assign_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == kma_pkg::KIND_ASSIGN
        |-> member_count == '0 && !cluster_empty)
        else $error("assignment result carries update fields");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !result_valid && !dist_valid)
        else $error("activity during clearing pass");

    a_div_only_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_UPD_DIV)
        else $error("divider finished outside an update");

endmodule

// ----- sv/kma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module kma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/kma_div.sv -----
// Restoring divider, one quotient bit per cycle.
module kma_div #(
    parameter int NUM_BITS = 36,
    parameter int DEN_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                run_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                take;

    assign trial = {rem_reg, quo_reg[NUM_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
                quo_reg <= num;
                rem_reg <= '0;
                den_reg <= den;
            end
            else if (run_reg)
            begin
                rem_reg <= take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
                quo_reg <= {quo_reg[NUM_BITS-2:0], take};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_BITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ----- sv/kma_dist.sv -----
// Shared subtract-square-accumulate unit for squared distances.
module kma_dist #(
    parameter int COORD_BITS = 16,
    parameter int CW = 9
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kma_pkg::dist_ctl_t           ctl,
    input  logic [CW-1:0]                cluster_in,
    input  logic signed [COORD_BITS-1:0] pt,
    input  logic signed [COORD_BITS-1:0] cen,
    output logic                         out_valid,
    output logic                         out_final,
    output logic [CW-1:0]                out_cluster,
    output logic [kma_pkg::DIST_BITS-1:0] out_dist
);

    localparam int DFW = COORD_BITS + 1;

    logic signed [DFW-1:0] diff;
    logic [DFW-1:0]        mag;
    logic [33:0]           mag_ext;

    kma_pkg::dist_ctl_t a_ctl_reg, b_ctl_reg;
    logic [CW-1:0]      a_c_reg, b_c_reg;
    logic [17:0]        a_mag_reg;
    logic               a_over_reg, b_over_reg;
    logic [kma_pkg::DIST_BITS-1:0] b_sq_reg;
    logic [kma_pkg::DIST_BITS-1:0] acc_reg;
    logic [kma_pkg::DIST_BITS-1:0] base;
    logic [kma_pkg::DIST_BITS:0]   sum;
    logic                out_valid_reg, out_final_reg;
    logic [CW-1:0]       out_c_reg;

    assign diff    = $signed({pt[COORD_BITS-1], pt}) - $signed({cen[COORD_BITS-1], cen});
    assign mag     = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
    assign mag_ext = 34'(mag);
    assign base    = b_ctl_reg.first ? '0 : acc_reg;
    assign sum     = {1'b0, base} + {1'b0, b_sq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg     <= '0;
            b_ctl_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_final_reg <= 1'b0;
        end
        else
        begin
            a_ctl_reg  <= ctl;
            a_c_reg    <= cluster_in;
            a_mag_reg  <= mag_ext[17:0];
            a_over_reg <= mag_ext >= 34'(1 << 18);

            b_ctl_reg  <= a_ctl_reg;
            b_c_reg    <= a_c_reg;
            b_over_reg <= a_over_reg;
            b_sq_reg   <= a_mag_reg * a_mag_reg;

            // A saturated partial sum stays saturated for the rest of the cluster.
            if (b_ctl_reg.valid)
            begin
                if (b_over_reg || sum > {1'b0, kma_pkg::DIST_MAX})
                begin
                    acc_reg <= kma_pkg::DIST_MAX;
                end
                else
                begin
                    acc_reg <= sum[kma_pkg::DIST_BITS-1:0];
                end
            end
            out_valid_reg <= b_ctl_reg.valid && b_ctl_reg.last;
            out_final_reg <= b_ctl_reg.valid && b_ctl_reg.final_item;
            out_c_reg     <= b_c_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_final   = out_final_reg;
    assign out_cluster = out_c_reg;
    assign out_dist    = acc_reg;

endmodule
